/* hw/rtl/rsn_pkg.sv */
// Shared types and field widths for the record sort block.
// No dependencies; compiled first.
`default_nettype none

package rsn_pkg;

  localparam int NAME_WORD_W   = 64;
  localparam int NAME_TAIL_W   = 24;
  localparam int QTY_W         = 32;
  localparam int PRICE_W       = 32;
  localparam int NAME_BYTES_HW = 19;
  localparam int NAME_W        = 2 * NAME_WORD_W + NAME_TAIL_W;

  // One stored record; the name keeps byte 0 in its top bits.
  typedef struct packed {
    logic [NAME_W-1:0]       name;
    logic signed [QTY_W-1:0] quantity;
    logic [PRICE_W-1:0]      price_bits;
  } rec_t;

endpackage

`default_nettype wire

/* hw/rtl/rsn_in_if.sv */
// Input channel interface: one record word per handshake.
// Depends on rsn_pkg for the field widths.
`default_nettype none

interface rsn_in_if import rsn_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [NAME_WORD_W-1:0]  name_word0;
  logic [NAME_WORD_W-1:0]  name_word1;
  logic [NAME_TAIL_W-1:0]  name_word2;
  logic signed [QTY_W-1:0] quantity;
  logic [PRICE_W-1:0]      price_bits;
  logic                    last;

  modport source (output valid, name_word0, name_word1, name_word2, quantity, price_bits,
                  last, input ready);
  modport sink (input valid, name_word0, name_word1, name_word2, quantity, price_bits,
                last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rsn_out_if.sv */
// Output channel interface: one sorted record word per handshake.
// Depends on rsn_pkg for the field widths.
`default_nettype none

interface rsn_out_if import rsn_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [NAME_WORD_W-1:0]  out_name_word0;
  logic [NAME_WORD_W-1:0]  out_name_word1;
  logic [NAME_TAIL_W-1:0]  out_name_word2;
  logic signed [QTY_W-1:0] out_quantity;
  logic [PRICE_W-1:0]      out_price_bits;
  logic                    out_last;

  modport source (output valid, out_name_word0, out_name_word1, out_name_word2,
                  out_quantity, out_price_bits, out_last, input ready);
  modport sink (input valid, out_name_word0, out_name_word1, out_name_word2,
                out_quantity, out_price_bits, out_last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/record_sort_by_name.sv */
// Record sorter: collects records, sorts them by name and streams them out.
// Depends on rsn_pkg, rsn_in_if and rsn_out_if.
// Record words are taken while loading. For n > 1 records the word marked last starts
// the sort at one name compare per cycle (none for a single record), and each sorted
// word is then held on the output until the sink takes it. A new set is taken only
// once the last sorted word has gone; synchronous rst empties the store.
`default_nettype none

module record_sort_by_name import rsn_pkg::*; #(
  parameter int MAX_RECORDS = 64,
  parameter int NAME_BYTES  = 19
) (
  input  wire         clk,
  input  wire         rst,
  rsn_in_if.sink      records,
  rsn_out_if.source   sorted
);

  localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_RDI    = 3'd1;
  localparam logic [2:0] S_LDI    = 3'd2;
  localparam logic [2:0] S_CMP    = 3'd3;
  localparam logic [2:0] S_WB     = 3'd4;
  localparam logic [2:0] S_EMRD   = 3'd5;
  localparam logic [2:0] S_EMLD   = 3'd6;
  localparam logic [2:0] S_EMHOLD = 3'd7;

  // Sort key: bytes after the terminator and beyond the name length read as
  // zero, so an unsigned compare of keys orders names as a string compare does.
  function automatic logic [NAME_W-1:0] name_key(input logic [NAME_W-1:0] name);
    logic [NAME_W-1:0] key;
    logic              ended;
    logic [7:0]        b;
    key   = '0;
    ended = 1'b0;
    for (int k = 0; k < NAME_BYTES_HW; k++) begin
      b = name[NAME_W-1-8*k -: 8];
      if (!ended && (k < NAME_BYTES)) begin
        key[NAME_W-1-8*k -: 8] = b;
      end
      if (b == 8'd0) begin
        ended = 1'b1;
      end
    end
    return key;
  endfunction

  logic [2:0]        state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  n;
  logic [IDX_W-1:0]  i;
  logic [IDX_W-1:0]  j;
  rec_t              cur;
  logic [NAME_W-1:0] cur_key;

  rec_t              mem [MAX_RECORDS];
  rec_t              rd_data;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  rec_t              wdata;
  logic [IDX_W-1:0]  raddr;

  rec_t              out_rec;
  logic              out_valid;
  logic              out_last;

  logic              in_acc;
  logic              full;
  logic [CNT_W-1:0]  new_n;
  logic [IDX_W-1:0]  n_m1;
  logic [IDX_W-1:0]  i_inc;
  logic [IDX_W-1:0]  j_inc;
  logic [NAME_W-1:0] rd_key;
  logic              swap;
  rec_t              in_rec;

  assign in_acc = records.valid && records.ready;
  assign full   = (count == CNT_W'(MAX_RECORDS));
  assign new_n  = full ? count : count + CNT_W'(1);
  assign n_m1   = IDX_W'(n - CNT_W'(1));
  assign i_inc  = i + IDX_W'(1);
  assign j_inc  = j + IDX_W'(1);
  assign rd_key = name_key(rd_data.name);
  assign swap   = (cur_key > rd_key);

  assign in_rec.name       = {records.name_word0, records.name_word1, records.name_word2};
  assign in_rec.quantity   = records.quantity;
  assign in_rec.price_bits = records.price_bits;

  // Memory port control for the current sequencer step.
  always_comb begin
    we    = 1'b0;
    waddr = i;
    wdata = cur;
    raddr = i;
    case (state)
      S_LOAD: begin
        we    = in_acc && !full;
        waddr = IDX_W'(count);
        wdata = in_rec;
      end
      S_LDI: begin
        raddr = i_inc;
      end
      S_CMP: begin
        we    = swap;
        waddr = j;
        wdata = cur;
        raddr = j_inc;
      end
      S_WB: begin
        we    = 1'b1;
        waddr = i;
        wdata = cur;
        raddr = i_inc;
      end
      default: begin
        raddr = i;
      end
    endcase
  end

  // Record memory with a registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  // Sequencer: load, exchange sort with the running minimum held in cur, emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            count <= new_n;
            if (records.last) begin
              n <= new_n;
              i <= '0;
              state <= (new_n == CNT_W'(1)) ? S_EMRD : S_RDI;
            end
          end
        end
        S_RDI: begin
          state <= S_LDI;
        end
        S_LDI: begin
          cur     <= rd_data;
          cur_key <= rd_key;
          j       <= i_inc;
          state   <= S_CMP;
        end
        S_CMP: begin
          if (swap) begin
            cur     <= rd_data;
            cur_key <= rd_key;
          end
          if (j == n_m1) begin
            state <= S_WB;
          end else begin
            j <= j_inc;
          end
        end
        S_WB: begin
          if (i_inc == n_m1) begin
            i     <= '0;
            state <= S_EMRD;
          end else begin
            i     <= i_inc;
            state <= S_LDI;
          end
        end
        S_EMRD: begin
          state <= S_EMLD;
        end
        S_EMLD: begin
          out_rec   <= rd_data;
          out_last  <= (i == n_m1);
          out_valid <= 1'b1;
          state     <= S_EMHOLD;
        end
        S_EMHOLD: begin
          if (sorted.ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              count <= '0;
              state <= S_LOAD;
            end else begin
              i     <= i_inc;
              state <= S_EMRD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // Port drive.
  assign records.ready         = (state == S_LOAD);
  assign sorted.valid          = out_valid;
  assign sorted.out_name_word0 = out_rec.name[NAME_W-1 -: NAME_WORD_W];
  assign sorted.out_name_word1 = out_rec.name[NAME_TAIL_W +: NAME_WORD_W];
  assign sorted.out_name_word2 = out_rec.name[NAME_TAIL_W-1:0];
  assign sorted.out_quantity   = out_rec.quantity;
  assign sorted.out_price_bits = out_rec.price_bits;
  assign sorted.out_last       = out_last;

endmodule

`default_nettype wire

/* hw/rtl/rsn_checker.sv */
// Port-level checks for the record sorter, attached by the bind below.
// Depends on rsn_pkg for the field widths.
`default_nettype none

module rsn_checker import rsn_pkg::*; (
  input wire                   clk,
  input wire                   rst,
  input wire                   in_valid,
  input wire                   in_ready,
  input wire                   in_last,
  input wire                   out_valid,
  input wire                   out_ready,
  input wire                   out_last,
  input wire [NAME_WORD_W-1:0] out_name_word0
);

  // No word is taken in while a sorted word is on offer.
  a_no_load_during_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while an output word is pending");

  // The final word of a set closes the set and the input opens again.
  a_reopen_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_last) |=> (in_ready && !out_valid))
    else $error("input not reopened after the final output word");

  // A word marked last ends the set, so the input closes.
  a_close_on_last: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_last) |=> !in_ready)
    else $error("input still ready after the final record");

  // Reset leaves nothing on the output.
  a_reset_clears_output: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output word valid straight after reset");

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_name_word0)
                                   && $stable(out_last)))
    else $error("output word changed while stalled");

endmodule

bind record_sort_by_name rsn_checker u_rsn_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (records.valid),
  .in_ready       (records.ready),
  .in_last        (records.last),
  .out_valid      (sorted.valid),
  .out_ready      (sorted.ready),
  .out_last       (sorted.out_last),
  .out_name_word0 (sorted.out_name_word0)
);

`default_nettype wire

/* bench/record_sort_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the record sorter: mirrors the record store, predicts the sorted
// stream whenever a word marked last arrives, and compares every output word.
// Depends on rsn_pkg, rsn_in_if and rsn_out_if.

module record_sort_checker import rsn_pkg::*; #(
  parameter int MAX_RECORDS = 64,
  parameter int NAME_BYTES  = 19
) (
  input  wire clk,
  input  wire rst,
  rsn_in_if   records,
  rsn_out_if  sorted,
  output int  failures,
  output int  pending
);

  typedef struct packed {
    rec_t rec;
    logic last;
  } sorted_word_t;

  rec_t         held_records [MAX_RECORDS];
  int           held_count = 0;
  sorted_word_t sorted_queue [$];
  int           mismatch_count = 0;

  // True when name a sorts after name b; bytes are unsigned and a byte that is
  // zero in both names ends the comparison as equal.
  function automatic bit name_after(input logic [NAME_W-1:0] a, input logic [NAME_W-1:0] b);
    logic [7:0] x;
    logic [7:0] y;
    for (int k = 0; k < NAME_BYTES; k++) begin
      x = a[NAME_W-1-8*k -: 8];
      y = b[NAME_W-1-8*k -: 8];
      if (x != y) return x > y;
      if (x == 8'h00) return 1'b0;
    end
    return 1'b0;
  endfunction

  // Exchange sort over the held set, then queue the words in the order of emission.
  task automatic sort_held_records();
    rec_t         tmp;
    sorted_word_t w;
    for (int i = 0; i < held_count; i++) begin
      for (int j = i + 1; j < held_count; j++) begin
        if (name_after(held_records[i].name, held_records[j].name)) begin
          tmp             = held_records[i];
          held_records[i] = held_records[j];
          held_records[j] = tmp;
        end
      end
    end
    for (int i = 0; i < held_count; i++) begin
      w.rec  = held_records[i];
      w.last = (i == held_count - 1);
      sorted_queue.push_back(w);
    end
    held_count = 0;
  endtask

  function automatic void check_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", field, want, got);
      mismatch_count++;
    end
  endfunction

  // Outputs are checked before inputs are taken: a word accepted at this edge
  // cannot yet have a result on the output side.
  always @(posedge clk) begin
    sorted_word_t want;
    if (rst) begin
      held_count = 0;
      sorted_queue.delete();
    end else begin
      if (sorted.valid && sorted.ready) begin
        if (sorted_queue.size() == 0) begin
          $error("unexpected output word: out_name_word0 %0h, out_last %0b",
                 sorted.out_name_word0, sorted.out_last);
          mismatch_count++;
        end else begin
          want = sorted_queue.pop_front();
          check_field("out_name_word0", want.rec.name[NAME_W-1 -: NAME_WORD_W],
                      sorted.out_name_word0);
          check_field("out_name_word1", want.rec.name[NAME_TAIL_W +: NAME_WORD_W],
                      sorted.out_name_word1);
          check_field("out_name_word2", want.rec.name[NAME_TAIL_W-1:0], sorted.out_name_word2);
          check_field("out_quantity", {want.rec.quantity}, {sorted.out_quantity});
          check_field("out_price_bits", want.rec.price_bits, sorted.out_price_bits);
          check_field("out_last", want.last, sorted.out_last);
        end
      end
      if (records.valid && records.ready) begin
        // A full store drops the word, but a last marker still starts the sort.
        if (held_count < MAX_RECORDS) begin
          held_records[held_count].name       = {records.name_word0, records.name_word1,
                                                 records.name_word2};
          held_records[held_count].quantity   = records.quantity;
          held_records[held_count].price_bits = records.price_bits;
          held_count++;
        end
        if (records.last) sort_held_records();
      end
    end
    failures <= mismatch_count;
    pending  <= sorted_queue.size();
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Top of the record sorter bench: clock, reset, record stimulus and output back-pressure.
// Depends on rsn_pkg, both channel interfaces, record_sort_by_name and record_sort_checker.

module testbench;
  import rsn_pkg::*;

  localparam int MAX_RECORDS  = 64;
  localparam int NAME_BYTES   = 19;
  localparam int RANDOM_ITEMS = 350;
  localparam int HOLD_AT_WORD = 20;
  localparam int HOLD_CYCLES  = 500;

  logic clk;
  logic rst;
  int   failures;
  int   pending;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   random_sent;

  rsn_in_if  records_ch ();
  rsn_out_if sorted_ch ();

  record_sort_by_name #(
    .MAX_RECORDS(MAX_RECORDS),
    .NAME_BYTES (NAME_BYTES)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .records(records_ch),
    .sorted (sorted_ch)
  );

  record_sort_checker #(
    .MAX_RECORDS(MAX_RECORDS),
    .NAME_BYTES (NAME_BYTES)
  ) scoreboard (
    .clk     (clk),
    .rst     (rst),
    .records (records_ch),
    .sorted  (sorted_ch),
    .failures(failures),
    .pending (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Packs a string into a name, first character in the top byte, zero padded.
  function automatic logic [NAME_W-1:0] text_name(input string s);
    logic [NAME_W-1:0] nm;
    nm = '0;
    for (int k = 0; k < s.len() && k < NAME_BYTES_HW; k++) nm[NAME_W-1-8*k -: 8] = s[k];
    return nm;
  endfunction

  // Mostly short names over a tiny alphabet so that ties and shared prefixes are
  // common; some straddle the sign boundary of a byte, some carry junk after the
  // terminator, some are raw bits and some repeat the previous name.
  function automatic logic [NAME_W-1:0] random_name(input logic [NAME_W-1:0] prev);
    logic [NAME_W-1:0] nm;
    logic [7:0]        base;
    int                len;
    int                mode;
    nm   = '0;
    mode = $urandom_range(0, 9);
    len  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NAME_BYTES_HW) : $urandom_range(1, 4);
    base = (mode == 5) ? 8'h7f : 8'h61;
    if (mode <= 6) begin
      for (int k = 0; k < len; k++) nm[NAME_W-1-8*k -: 8] = base + 8'($urandom_range(0, 2));
      if (mode == 6) begin
        for (int k = len + 1; k < NAME_BYTES_HW; k++) nm[NAME_W-1-8*k -: 8] = 8'($urandom);
      end
    end else if (mode <= 8) begin
      nm = NAME_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
    end else begin
      nm = prev;
    end
    return nm;
  endfunction

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h8000_0000;
      3:       return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Offers one record word, idling first at random, and returns once it is taken.
  task automatic push_record(input rec_t r, input logic is_last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      records_ch.valid <= 1'b0;
      @(posedge clk);
    end
    records_ch.valid      <= 1'b1;
    records_ch.name_word0 <= r.name[NAME_W-1 -: NAME_WORD_W];
    records_ch.name_word1 <= r.name[NAME_TAIL_W +: NAME_WORD_W];
    records_ch.name_word2 <= r.name[NAME_TAIL_W-1:0];
    records_ch.quantity   <= r.quantity;
    records_ch.price_bits <= r.price_bits;
    records_ch.last       <= is_last;
    @(posedge clk);
    while (!records_ch.ready) @(posedge clk);
  endtask

  task automatic push_text(input logic [NAME_W-1:0] nm, input logic [31:0] qty,
                           input logic [31:0] price, input logic is_last);
    rec_t r;
    r.name       = nm;
    r.quantity   = qty;
    r.price_bits = price;
    push_record(r, is_last);
  endtask

  task automatic send_random_set(input int n);
    rec_t              r;
    logic [NAME_W-1:0] prev;
    prev = '0;
    for (int i = 0; i < n; i++) begin
      r.name       = random_name(prev);
      r.quantity   = random_word();
      r.price_bits = random_word();
      prev         = r.name;
      push_record(r, i == n - 1);
    end
    random_sent += n;
  endtask

  // One large set opens each phase; small sets fill the rest.
  task automatic run_random_phase(input int upto, input int big_set);
    send_random_set(big_set);
    while (random_sent < upto) send_random_set($urandom_range(1, 10));
  endtask

  // Receiver: random ready, with one long hold-off part way through a large set
  // while the sender keeps offering words.
  initial begin
    int taken;
    bit held;
    taken = 0;
    held  = 0;
    sorted_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sorted_ch.valid && sorted_ch.ready) taken++;
      if (taken == HOLD_AT_WORD && !held) begin
        held = 1;
        sorted_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        sorted_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [NAME_W-1:0] nm;
    int                drain_cycles;
    records_ch.valid      <= 1'b0;
    records_ch.name_word0 <= '0;
    records_ch.name_word1 <= '0;
    records_ch.name_word2 <= '0;
    records_ch.quantity   <= '0;
    records_ch.price_bits <= '0;
    records_ch.last       <= 1'b0;
    rst                   <= 1'b1;
    send_idle_pct = 36;
    recv_idle_pct = 66;
    random_sent   = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // A set of one word with every field at its top value.
    push_text('1, 32'h7fff_ffff, 32'hffff_ffff, 1'b1);

    // Empty name, case, unsigned bytes, junk after the terminator, a tie
    // with an earlier word and names that differ only in the final byte.
    push_text(text_name("pear"), 32'h8000_0000, 32'h0000_0000, 1'b0);
    push_text('0, 32'h0000_0000, 32'h0000_0001, 1'b0);
    push_text(text_name("apple"), 32'hffff_ffff, $urandom, 1'b0);
    push_text(text_name("Apple"), $urandom, $urandom, 1'b0);
    nm = text_name("apple");
    nm[103:0] = 104'({$urandom, $urandom, $urandom, $urandom});
    push_text(nm, $urandom, $urandom, 1'b0);
    push_text(text_name("abcdefghijklmnopqrs"), 32'h7fff_ffff, $urandom, 1'b0);
    push_text(text_name("abcdefghijklmnopqrr"), $urandom, 32'hffff_ffff, 1'b0);
    nm = '0;
    nm[NAME_W-1 -: 8] = 8'h80;
    push_text(nm, $urandom, $urandom, 1'b0);
    push_text(text_name("zz"), $urandom, $urandom, 1'b1);

    // A set already in descending order.
    push_text(text_name("c"), 32'd3, 32'd30, 1'b0);
    push_text(text_name("b"), 32'd2, 32'd20, 1'b0);
    push_text(text_name("a"), 32'd1, 32'd10, 1'b1);

    // Random sets: an exactly full store, then two overfull stores whose
    // last-marked word is dropped but still starts the sort.
    run_random_phase(RANDOM_ITEMS / 3, MAX_RECORDS);
    send_idle_pct = 66;
    recv_idle_pct = 36;
    run_random_phase(2 * RANDOM_ITEMS / 3, MAX_RECORDS + 2);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(RANDOM_ITEMS, MAX_RECORDS + 1);
    records_ch.valid <= 1'b0;

    // Drain the outstanding words, then watch a while for strays.
    @(posedge clk);
    drain_cycles = 0;
    while (pending != 0 && drain_cycles < 200000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (100) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/rsn_pkg.sv
hw/rtl/rsn_in_if.sv
hw/rtl/rsn_out_if.sv
hw/rtl/record_sort_by_name.sv
hw/rtl/rsn_checker.sv
bench/record_sort_checker.sv
bench/testbench.sv
